>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/btsl_pkg.sv
// ----------------------------------------------------------------------------
// btsl_pkg
// Types and constants for the bitmap trie sparse lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package btsl_pkg;

  localparam int KeyBits  = 32;
  localparam int NodeBits = 8;

  localparam logic [1:0] OP_LOAD_LEVEL = 2'd0;
  localparam logic [1:0] OP_LOAD_VALUE = 2'd1;
  localparam logic [1:0] OP_LOOKUP     = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  level;
    logic [11:0] address;
    logic [7:0]  data;
    logic [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [13:0] value_index;
    logic [7:0]  value;
    logic        value_in_range;
  } out_word_t;

  typedef struct packed {
    logic init;
    logic lvl_start;
    logic scan_add;
    logic lvl_next;
    logic res_found;
    logic res_miss;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lvl_done;
    logic lvl_bad;
    logic scan_last;
    logic bit_set;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [3:0] popcount8(input logic [NodeBits-1:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < NodeBits; i++) begin
      n = n + {3'b0, b[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/btsl_ctrl.sv
// ----------------------------------------------------------------------------
// btsl_ctrl
// Lookup sequencer: walks levels, scans bitmap bytes for the rank.
// ----------------------------------------------------------------------------
`default_nettype none

module btsl_ctrl
  import btsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_acc_i,
  input  logic      in_lookup_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LVL, S_RD, S_EV, S_VRD, S_VEV, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc_i && in_lookup_i) begin
          cmd_o.init = 1'b1;
          state_d    = S_LVL;
        end
      end
      S_LVL: begin
        if (sts_i.lvl_done) begin
          state_d = S_VRD;
        end else if (sts_i.lvl_bad) begin
          cmd_o.res_miss = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.lvl_start = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        if (!sts_i.scan_last) begin
          cmd_o.scan_add = 1'b1;
          state_d        = S_RD;
        end else if (!sts_i.bit_set) begin
          cmd_o.res_miss = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.lvl_next = 1'b1;
          state_d        = S_LVL;
        end
      end
      S_VRD: state_d = S_VEV;
      S_VEV: begin
        cmd_o.res_found = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/btsl_datapath.sv
// ----------------------------------------------------------------------------
// btsl_datapath
// Bitmap and value memories, rank accumulator and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module btsl_datapath
  import btsl_pkg::*;
#(
  parameter int LEVEL_BYTES = 1024,
  parameter int MAX_LEVELS  = 32,
  parameter int VALUE_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_acc_i,
  input  in_word_t   in_word_i,
  input  logic       out_stall_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_sts_t  sts_o,
  output logic       out_valid_o,
  output out_word_t  out_word_o
);

  localparam int MemDepth = MAX_LEVELS * LEVEL_BYTES;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int IdxW     = $clog2(LEVEL_BYTES);
  localparam int OffW     = $clog2(LEVEL_BYTES * NodeBits + 1);
  localparam int ValAw    = $clog2(VALUE_BYTES);

  logic [7:0] lvl_mem [MemDepth];
  logic [7:0] val_mem [VALUE_BYTES];

  logic [1:0]      bpl_q;
  logic [31:0]     key_q;
  logic [5:0]      lvl_q;
  logic [OffW-1:0] off_q;
  logic [IdxW-1:0] idx_q;
  logic [OffW-1:0] cnt_q;
  logic [7:0]      lvl_rd_q;
  logic [7:0]      val_rd_q;
  out_word_t       res_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic [1:0]  bpl;
  logic [5:0]  n_levels;
  logic [31:0] sh;
  logic [2:0]  child;
  logic [7:0]  below_mask;
  logic [31:0] off32;
  logic [31:0] rd_addr;
  logic [31:0] wr_addr;
  logic        in_range;

  always_comb begin
    bpl = (bpl_q == 2'd0) ? 2'd1 : bpl_q;
    case (bpl)
      2'd1:    n_levels = 6'd32;
      2'd2:    n_levels = 6'd16;
      default: n_levels = 6'd11;
    endcase
    sh         = 32'(bpl) * 32'(n_levels - 6'd1 - lvl_q);
    child      = 3'(key_q >> sh[4:0]) & ((3'd1 << bpl) - 3'd1);
    below_mask = (8'd1 << child) - 8'd1;
    off32      = 32'(off_q);
    rd_addr    = 32'(lvl_q) * 32'(LEVEL_BYTES) + 32'(idx_q);
    wr_addr    = 32'(in_word_i.level) * 32'(LEVEL_BYTES) + 32'(in_word_i.address);
    in_range   = off32 < 32'(VALUE_BYTES);
  end

  always_comb begin
    sts_o.lvl_done  = (lvl_q == n_levels);
    sts_o.lvl_bad   = (32'(lvl_q) >= 32'(MAX_LEVELS)) || (off32 >= 32'(LEVEL_BYTES));
    sts_o.scan_last = (32'(idx_q) == off32);
    sts_o.bit_set   = lvl_rd_q[child];
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && in_word_i.opcode == OP_LOAD_LEVEL &&
        32'(in_word_i.level) < 32'(MAX_LEVELS) &&
        32'(in_word_i.address) < 32'(LEVEL_BYTES)) begin
      lvl_mem[wr_addr[MemAw-1:0]] <= in_word_i.data;
    end
    lvl_rd_q <= lvl_mem[rd_addr[MemAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && in_word_i.opcode == OP_LOAD_VALUE &&
        32'(in_word_i.address) < 32'(VALUE_BYTES)) begin
      val_mem[in_word_i.address[ValAw-1:0]] <= in_word_i.data;
    end
    val_rd_q <= val_mem[off32[ValAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      key_q <= in_word_i.key;
      lvl_q <= '0;
      off_q <= '0;
    end
    if (cmd_i.lvl_start) begin
      idx_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.scan_add) begin
      idx_q <= idx_q + IdxW'(1);
      cnt_q <= cnt_q + OffW'(popcount8(lvl_rd_q));
    end
    if (cmd_i.lvl_next) begin
      off_q <= cnt_q + OffW'(popcount8(lvl_rd_q & below_mask));
      lvl_q <= lvl_q + 6'd1;
    end
    if (cmd_i.res_miss) begin
      res_q <= '0;
    end
    if (cmd_i.res_found) begin
      res_q.found          <= 1'b1;
      res_q.value_index    <= off32[13:0];
      res_q.value          <= in_range ? val_rd_q : 8'd0;
      res_q.value_in_range <= in_range;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q       <= 2'd3;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bpl_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_trie_sparse_lookup_top.sv
// ----------------------------------------------------------------------------
// bitmap_trie_sparse_lookup_top
// Sparse array lookup through a trie of per-level child bitmaps.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_word_i) takes load and lookup
// words. Loads write a level bitmap byte or a value byte and give no
// result. A lookup gives one output word on out_valid_o/out_word_o.
// cfg_we_i writes bits_per_level (reset 3); the user must write it only while
// the block is idle, as the block itself does not enforce this. A lookup
// walks the levels in turn and ends in a miss when a child bit is clear or
// when a level or an offset is out of range; a hit then reads the value
// byte. The rank is counted by scanning that level's bitmap one byte per
// memory read, from the first byte up to the node byte offset. One
// lookup is in flight at a time; in_stall_o stays high until its result is
// in the output register. The output register holds a word until taken;
// while out_stall_i is high a new load or lookup is still accepted, and a
// finished lookup waits for the register to free up. Reset clears control
// state and the valid flag; the memories hold whatever was loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_trie_sparse_lookup_top
  import btsl_pkg::*;
#(
  parameter int LEVEL_BYTES = 1024,
  parameter int MAX_LEVELS  = 32,
  parameter int VALUE_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      busy;
  logic      in_acc;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;

  btsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .in_lookup_i (in_word_i.opcode == OP_LOOKUP),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  btsl_datapath #(
    .LEVEL_BYTES (LEVEL_BYTES),
    .MAX_LEVELS  (MAX_LEVELS),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_acc_i    (in_acc),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/btsl_checker.sv
// ----------------------------------------------------------------------------
// btsl_checker
// Port-level checks for the bitmap trie sparse lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module btsl_checker
  import btsl_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `ASSERT_NEXT(a_busy_after_lookup, in_valid_i && !in_stall_o && in_word_i.opcode == OP_LOOKUP, in_stall_o, "lookup accepted without going busy")
  `ASSERT_IMPL(a_miss_zero, out_valid_o && !out_word_o.found, out_word_o.value_index == 14'd0 && out_word_o.value == 8'd0 && !out_word_o.value_in_range, "miss word not all zero")
  `ASSERT_IMPL(a_range_found, out_valid_o && out_word_o.value_in_range, out_word_o.found, "value in range without found")

endmodule

bind bitmap_trie_sparse_lookup_top btsl_checker u_btsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

>>> tb/sv/btsl_checker.sv
// ----------------------------------------------------------------------------
// btsl_tb_checker
// Watches the load/lookup and result channels of the bitmap trie lookup,
// keeps its own copy of the trie and value bytes, predicts every lookup
// result and compares it with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module btsl_tb_checker
  import btsl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_word_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_word_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         hits_o
);

  localparam int LevelBytes = 1024;
  localparam int MaxLevels  = 32;
  localparam int ValueBytes = 4096;

  logic [7:0] trie_mem [0:MaxLevels*LevelBytes-1];
  logic [7:0] value_mem [0:ValueBytes-1];
  logic [1:0] key_bits_per_level;
  out_word_t  lookup_q[$];

  function automatic logic [7:0] node_byte(int lvl, int off);
    if (lvl >= MaxLevels || off >= LevelBytes) return 8'h00;
    return trie_mem[lvl*LevelBytes + off];
  endfunction

  function automatic out_word_t walk_trie(logic [31:0] key);
    out_word_t r;
    int b, nlev, off, shift, child, rank;
    logic [7:0] node;
    r = '0;
    b = (key_bits_per_level == 2'd0) ? 1 : int'(key_bits_per_level);
    nlev = (KeyBits + b - 1) / b;
    off = 0;
    for (int lvl = 0; lvl < nlev; lvl++) begin
      shift = b * (nlev - lvl - 1);
      child = int'((key >> shift) & ((32'd1 << b) - 1));
      node = node_byte(lvl, off);
      if (!node[child]) return r;
      rank = 0;
      for (int o = 0; o < off; o++) rank += $countones(node_byte(lvl, o));
      rank += $countones(node & ((8'd1 << child) - 8'd1));
      off = rank;
    end
    r.found = 1'b1;
    r.value_index = off[13:0];
    if (off < ValueBytes) begin
      r.value = value_mem[off];
      r.value_in_range = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      key_bits_per_level = 2'd3;
      lookup_q.delete();
      fail_count_o = 0;
      hits_o = 0;
    end else begin
      if (cfg_we_i) key_bits_per_level = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result word %h", out_word_i);
          fail_count_o++;
        end else begin
          exp_w = lookup_q.pop_front();
          if (exp_w.found !== out_word_i.found ||
              exp_w.value_index !== out_word_i.value_index ||
              exp_w.value !== out_word_i.value ||
              exp_w.value_in_range !== out_word_i.value_in_range) begin
            if (fail_count_o < 10)
              $display("mismatch: exp found=%0d idx=%0d val=%h inr=%0d, got %0d %0d %h %0d",
                       exp_w.found, exp_w.value_index, exp_w.value, exp_w.value_in_range,
                       out_word_i.found, out_word_i.value_index, out_word_i.value,
                       out_word_i.value_in_range);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_word_i.opcode)
          OP_LOAD_LEVEL: begin
            if (in_word_i.address < LevelBytes)
              trie_mem[int'(in_word_i.level)*LevelBytes + int'(in_word_i.address)] =
                in_word_i.data;
          end
          OP_LOAD_VALUE: value_mem[in_word_i.address] = in_word_i.data;
          OP_LOOKUP: begin
            exp_w = walk_trie(in_word_i.key);
            if (exp_w.found) hits_o++;
            lookup_q = {lookup_q, exp_w};
          end
          default: ;
        endcase
      end
    end
    pending_o = lookup_q.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/bitmap_trie_sparse_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// bitmap_trie_sparse_lookup_top_tb
// Builds small tries under every bits-per-level setting, then runs directed
// and random lookups (hit paths, random keys, ignored loads) with random
// stalls on both sides; results are checked by btsl_tb_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_trie_sparse_lookup_top_tb;
  import btsl_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic       in_valid_i, in_stall_o;
  in_word_t   in_word_i;
  logic       out_valid_o, out_stall_i;
  out_word_t  out_word_o;
  int         fail_count, pending, hits;
  int         cyc, words_sent, lookups_sent;
  logic [7:0] shadow_trie [0:31][0:15];
  int         cur_bits, cur_width;

  bitmap_trie_sparse_lookup_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  btsl_tb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .fail_count_o(fail_count), .pending_o(pending), .hits_o(hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic quiet();
    return cyc >= 6000 && cyc < 10000;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("bitmap_trie_sparse_lookup_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cyc == 4000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet()) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 19);
      end
    end
  end

  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (w.opcode == OP_LOOKUP) lookups_sent++;
    @(negedge clk_i);
    if (!quiet() && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_op(logic [1:0] op, int lvl, int addr, int data, logic [31:0] key);
    in_word_t w;
    w.opcode = op;
    w.level = lvl[4:0];
    w.address = addr[11:0];
    w.data = data[7:0];
    w.key = key;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // walks set bits of the shadow trie; leaves the key random from a random level on when asked
  function automatic logic [31:0] hit_key(int miss_pct);
    logic [31:0] key;
    logic [7:0]  node, avail;
    int nlev, off, shift, w, child, rank;
    key = $urandom();
    nlev = (32 + cur_bits - 1) / cur_bits;
    off = 0;
    for (int lvl = 0; lvl < nlev; lvl++) begin
      shift = cur_bits * (nlev - lvl - 1);
      w = (32 - shift < cur_bits) ? 32 - shift : cur_bits;
      avail = (8'd1 << w) - 8'd1;
      node = shadow_trie[lvl][off] & avail;
      if (node == 8'h00 || $urandom_range(0, 99) < miss_pct) return key;
      do child = $urandom_range(0, int'(avail)); while (!node[child]);
      key = (key & ~(((32'd1 << w) - 1) << shift)) | (32'(child) << shift);
      rank = 0;
      for (int o = 0; o < off; o++) rank += $countones(shadow_trie[lvl][o]);
      rank += $countones(shadow_trie[lvl][off] & ((8'd1 << child) - 8'd1));
      off = rank;
    end
    return key;
  endfunction

  initial begin
    int bits_set [6] = '{3, 1, 2, 0, 3, 2};
    int width_set [6] = '{4, 2, 8, 3, 6, 5};
    int budget, r, pick;
    cyc = 0;
    words_sent = 0;
    lookups_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 2'd3;
    in_valid_i = 1'b0;
    in_word_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= bits_set[ph][1:0];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      cur_bits = (bits_set[ph] == 0) ? 1 : bits_set[ph];
      cur_width = width_set[ph];
      for (int a = 0; a < 16; a++) send_op(OP_LOAD_VALUE, 0, a, $urandom_range(0, 255), 0);
      // each level keeps at most cur_width set bits, so every rank stays
      // inside the bytes written in this phase
      for (int lvl = 0; lvl < 32; lvl++) begin
        budget = cur_width;
        for (int o = 0; o < cur_width; o++) begin
          r = $urandom_range(0, 255);
          while ($countones(r[7:0]) > budget) r = r & (r - 1);
          budget -= $countones(r[7:0]);
          shadow_trie[lvl][o] = r[7:0];
          send_op(OP_LOAD_LEVEL, lvl, o, r, 0);
        end
      end
      if (ph == 0) begin
        send_op(OP_LOOKUP, 0, 0, 0, 32'h0000_0000);
        send_op(OP_LOOKUP, 0, 0, 0, 32'hffff_ffff);
        send_op(OP_UNUSED, 31, 4095, 255, 32'hffff_ffff);
        send_op(OP_LOAD_LEVEL, 31, 4095, 255, 0);
        send_op(OP_LOAD_LEVEL, 0, 1024, 255, 0);
        send_op(OP_LOAD_VALUE, 31, 4095, 255, 0);
        send_op(OP_LOAD_VALUE, 0, 4095, 0, 0);
        send_op(OP_LOAD_VALUE, 0, 0, 255, 0);
        send_op(OP_LOAD_VALUE, 0, 1, 0, 0);
        for (int i = 0; i < 8; i++) send_op(OP_LOOKUP, 0, 0, 0, hit_key(0));
        send_op(OP_LOOKUP, 0, 0, 0, hit_key(30));
        drain();
      end
      for (int i = 0; i < 120; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) send_op(OP_LOOKUP, $urandom_range(0, 31), $urandom_range(0, 4095),
                               $urandom_range(0, 255), hit_key(8));
        else if (pick < 80) send_op(OP_LOOKUP, 0, 0, 0, $urandom());
        else if (pick < 87) send_op(OP_UNUSED, $urandom_range(0, 31),
                                    $urandom_range(0, 4095), $urandom_range(0, 255),
                                    $urandom());
        else if (pick < 94) send_op(OP_LOAD_LEVEL, $urandom_range(0, 31),
                                    $urandom_range(1024, 4095), $urandom_range(0, 255), 0);
        else send_op(OP_LOAD_VALUE, 0, $urandom_range(0, 4095), $urandom_range(0, 255), 0);
      end
      drain();
    end

    $display("covered %0d words, %0d lookups (%0d hits) over 6 trie settings",
             words_sent, lookups_sent, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_trie_sparse_lookup_top_tb: PASS");
    end else begin
      $display("bitmap_trie_sparse_lookup_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
